FILE: hw/rtl/cfl_pkg.sv
// Connection flood limiter: shared types, constants and state codes.
// No dependencies.
package cfl_pkg;

    localparam int ENTRIES = 512;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = IDX_W + 1;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_BONUS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_OFS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SCALE = 3'd5;

    localparam logic [15:0] RST_EXPIRY      = 16'd660;
    localparam logic [15:0] RST_SCORE_LIMIT = 16'd100;
    localparam logic [15:0] RST_COUNT_LIMIT = 16'd15;
    localparam logic [15:0] RST_SCORE_BONUS = 16'd30;
    localparam logic [15:0] RST_DECAY_OFS   = 16'd15;
    localparam logic [15:0] RST_DECAY_SCALE = 16'd20;

    localparam logic [23:0] SCORE_MAX = 24'hFFFFFF;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;
    localparam logic [9:0]  REL_MAX   = 10'd1023;

    localparam int DVD_W = 40;
    localparam int DVS_W = 17;

    typedef struct packed {
        logic [31:0] time_s;
        logic [23:0] score;
        logic [15:0] count;
    } entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_MUL,
        ST_DIV,
        ST_UPD,
        ST_MISS
    } state_t;

endpackage

FILE: hw/rtl/cfl_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module cfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/cfl_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on cfl_pkg.
module cfl_div
    import cfl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int STEP_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    rem_sub;

    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
            step_next = STEP_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sub[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DVS_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;
endmodule

FILE: hw/rtl/connection_flood_limiter.sv
// Connection flood limiter top level: config registers, table walk FSM, table RAMs.
// Depends on cfl_pkg, cfl_ram, cfl_div.
//
// Channel  | Dir | Handshake          | Content
// s_       | in  | s_tvalid/s_tready  | one connection attempt
// m_       | out | m_tvalid/m_tready  | one verdict per attempt
// cfg_     | in  | cfg_valid/cfg_ready| register index and value
//
// An item takes one table pass on a miss (one entry read per cycle from the table RAM);
// a hit ends the walk at that entry and, unless the entry is blocked, runs the divider.
// After reset a clearing pass zeroes the table; no item is taken then.
// One item is in work at a time; the next is taken once the verdict sits in the output
// register, and a stalled output holds the next verdict back.
module connection_flood_limiter
    import cfl_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,  // source_address[31:0], now_seconds[63:32]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,  // accept[0], newly_blocked[1], releases[11:2],
                                           // attempt_count[27:12], zero[31:28]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);
    state_t state_reg, state_next;

    logic [15:0] expiry_reg, slimit_reg, climit_reg, bonus_reg, dofs_reg, dscale_reg;

    logic [31:0] addr_reg, addr_next;
    logic [31:0] now_reg, now_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             ev_vld_reg, ev_vld_next;
    logic [IDX_W-1:0] ev_idx_reg, ev_idx_next;
    logic [9:0]  rel_reg, rel_next;
    logic [32:0] bu_reg, bu_next, ba_reg, ba_next;
    logic [IDX_W-1:0] vu_reg, vu_next, va_reg, va_next;
    logic        found_reg, found_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    entry_t      hit_reg, hit_next;
    logic        was_reg, was_next;
    logic [15:0] gap_reg, gap_next;
    logic [DVD_W-1:0] prod_reg, prod_next;
    logic        dz_reg, dz_next;

    logic        mv_reg, mv_next;
    logic [31:0] md_reg, md_next;

    logic             tw_we, aw_we;
    logic [IDX_W-1:0] tw_addr, rd_addr;
    entry_t           tw_data, rd_entry;
    logic [31:0]      rd_addr_q;

    logic             div_start, div_done;
    logic [DVD_W-1:0] div_q;
    logic [DVS_W-1:0] den;

    logic        out_free, s_acc, last_ev;
    logic        ev_live, ev_stale, ev_blk, ev_hit;
    logic [31:0] ev_gap;
    logic [32:0] ev_eff;
    logic [DVD_W-1:0] q_raw;
    logic [DVD_W:0] qb;
    logic [23:0] sc_new;
    logic [15:0] cnt_new;
    logic        blk_new;
    logic [IDX_W-1:0] victim;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;

    cfl_ram #(.WIDTH($bits(entry_t)), .DEPTH(ENTRIES)) u_tab (
        .aclk(aclk), .we(tw_we), .waddr(tw_addr), .wdata(tw_data),
        .raddr(rd_addr), .rdata(rd_entry)
    );

    cfl_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_addr (
        .aclk(aclk), .we(aw_we), .waddr(tw_addr), .wdata(addr_reg),
        .raddr(rd_addr), .rdata(rd_addr_q)
    );

    cfl_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(prod_reg), .divisor(den), .done(div_done), .quotient(div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expiry_reg <= RST_EXPIRY;
            slimit_reg <= RST_SCORE_LIMIT;
            climit_reg <= RST_COUNT_LIMIT;
            bonus_reg  <= RST_SCORE_BONUS;
            dofs_reg   <= RST_DECAY_OFS;
            dscale_reg <= RST_DECAY_SCALE;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_EXPIRY:      expiry_reg <= cfg_data;
                CFG_SCORE_LIMIT: slimit_reg <= cfg_data;
                CFG_COUNT_LIMIT: climit_reg <= cfg_data;
                CFG_SCORE_BONUS: bonus_reg  <= cfg_data;
                CFG_DECAY_OFS:   dofs_reg   <= cfg_data;
                CFG_DECAY_SCALE: dscale_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-entry evaluation during the walk, plus the new score, count and victim for the update
    always_comb begin
        ev_live  = (rd_entry.time_s != '0);
        ev_gap   = now_reg - rd_entry.time_s;
        ev_stale = ev_live && ((now_reg < rd_entry.time_s) || (ev_gap > {16'd0, expiry_reg}));
        ev_blk   = (rd_entry.score > {slimit_reg, 8'd0}) && (rd_entry.count > climit_reg);
        ev_hit   = ev_vld_reg && ev_live && !ev_stale && (rd_addr_q == addr_reg);
        ev_eff   = ev_stale ? 33'd0 : {1'b0, rd_entry.time_s};
        last_ev  = ev_vld_reg && (ev_idx_reg == IDX_W'(ENTRIES - 1));
        den      = {1'b0, gap_reg} + {1'b0, dofs_reg};
        q_raw    = dz_reg ? ((hit_reg.score == '0) ? '0 : {{(DVD_W-24){1'b0}}, SCORE_MAX})
                          : div_q;
        qb       = {1'b0, q_raw} + {{(DVD_W-23){1'b0}}, bonus_reg, 8'd0};
        sc_new   = was_reg ? hit_reg.score
                 : ((qb > {{(DVD_W-23){1'b0}}, SCORE_MAX}) ? SCORE_MAX : qb[23:0]);
        cnt_new  = (hit_reg.count == COUNT_MAX) ? COUNT_MAX : hit_reg.count + 16'd1;
        blk_new  = (sc_new > {slimit_reg, 8'd0}) && (cnt_new > climit_reg);
        victim   = found_reg ? vu_reg : va_reg;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (idx_reg == CNT_W'(ENTRIES - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (s_acc) state_next = ST_WALK;
            ST_WALK: begin
                if (ev_hit) begin
                    state_next = ev_blk ? ST_UPD : ST_MUL;
                end else if (last_ev) begin
                    state_next = ST_MISS;
                end
            end
            ST_MUL:   state_next = ST_DIV;
            ST_DIV:   if (dz_reg || div_done) state_next = ST_UPD;
            ST_UPD:   if (out_free) state_next = ST_IDLE;
            ST_MISS:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        addr_next = addr_reg;   now_next = now_reg;
        idx_next = idx_reg;     ev_vld_next = 1'b0;  ev_idx_next = ev_idx_reg;
        rel_next = rel_reg;
        bu_next = bu_reg; ba_next = ba_reg; vu_next = vu_reg; va_next = va_reg;
        found_next = found_reg;
        hit_idx_next = hit_idx_reg; hit_next = hit_reg; was_next = was_reg;
        gap_next = gap_reg; prod_next = prod_reg; dz_next = dz_reg;
        mv_next = mv_reg && !m_tready; md_next = md_reg;
        tw_we = 1'b0; aw_we = 1'b0; tw_addr = ev_idx_reg; tw_data = rd_entry;
        rd_addr = idx_reg[IDX_W-1:0];
        div_start = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                tw_we = 1'b1;
                tw_addr = idx_reg[IDX_W-1:0];
                tw_data = '0;
                idx_next = idx_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_acc) begin
                    addr_next = s_tdata[31:0];
                    now_next  = s_tdata[63:32];
                    idx_next  = '0;
                    rel_next  = '0;
                    bu_next   = {1'b0, s_tdata[63:32]} + 33'd1;
                    ba_next   = {1'b0, s_tdata[63:32]} + 33'd1;
                    vu_next   = '0; va_next = '0; found_next = 1'b0;
                end
            end
            ST_WALK: begin
                if (ev_vld_reg && ev_stale) begin
                    tw_we = 1'b1;
                    tw_data.time_s = '0;
                    if (ev_blk && rel_reg != REL_MAX) rel_next = rel_reg + 10'd1;
                end
                if (ev_vld_reg && !ev_hit) begin
                    if (ev_eff < bu_reg && !ev_blk) begin
                        bu_next = ev_eff; vu_next = ev_idx_reg; found_next = 1'b1;
                    end
                    if (ev_eff < ba_reg) begin
                        ba_next = ev_eff; va_next = ev_idx_reg;
                    end
                end
                if (ev_hit) begin
                    hit_idx_next = ev_idx_reg;
                    hit_next = rd_entry;
                    was_next = ev_blk;
                    gap_next = ev_gap[15:0];
                    prod_next = {16'd0, rd_entry.score} * {24'd0, dscale_reg};
                end else if (idx_reg < CNT_W'(ENTRIES)) begin
                    ev_vld_next = 1'b1;
                    ev_idx_next = idx_reg[IDX_W-1:0];
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_MUL: begin
                dz_next = (den == '0);
                div_start = (den != '0);
            end
            ST_DIV: ;
            ST_UPD: begin
                if (out_free) begin
                    tw_we = 1'b1;
                    tw_addr = hit_idx_reg;
                    tw_data.time_s = blk_new ? hit_reg.time_s : now_reg;
                    tw_data.score = sc_new;
                    tw_data.count = cnt_new;
                    mv_next = 1'b1;
                    md_next = {4'd0, cnt_new, rel_reg, blk_new && !was_reg, !blk_new};
                end
            end
            ST_MISS: begin
                if (out_free) begin
                    tw_we = 1'b1;
                    aw_we = 1'b1;
                    tw_addr = victim;
                    tw_data.time_s = now_reg;
                    tw_data.score = '0;
                    tw_data.count = 16'd1;
                    mv_next = 1'b1;
                    md_next = {4'd0, 16'd1,
                               (!found_reg && rel_reg != REL_MAX) ? rel_reg + 10'd1 : rel_reg,
                               1'b0, 1'b1};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_CLEAR;
            idx_reg    <= '0;
            ev_vld_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            ev_vld_reg <= ev_vld_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;     now_reg <= now_next;
        ev_idx_reg <= ev_idx_next; rel_reg <= rel_next;
        bu_reg <= bu_next; ba_reg <= ba_next; vu_reg <= vu_next; va_reg <= va_next;
        found_reg <= found_next;
        hit_idx_reg <= hit_idx_next; hit_reg <= hit_next; was_reg <= was_next;
        gap_reg <= gap_next; prod_reg <= prod_next; dz_reg <= dz_next;
        md_reg <= md_next;
    end

`ifndef SYNTHESIS
    a_take_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> state_reg == ST_WALK)
        else $error("item taken but walk not started");
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside divide state");
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        aw_we |-> tw_we && state_reg == ST_MISS)
        else $error("address written without entry write");
`endif
endmodule

FILE: tb/tb.sv
// Testbench for connection_flood_limiter: attempts are driven on the s_ stream and
// verdicts checked against an in-bench model of the address table. Depends on cfl_pkg and connection_flood_limiter.
`timescale 1ns / 100ps

module tb
    import cfl_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam int LIMIT_CYCLES = 5000000;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

    typedef struct packed {
        logic [15:0] attempt_count;
        logic [9:0]  releases;
        logic        newly_blocked;
        logic        accept;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    connection_flood_limiter dut (.*);

    always #6 aclk = ~aclk;

    // address table model
    logic [31:0] tbl_addr  [ENTRIES];
    logic [31:0] tbl_time  [ENTRIES];
    logic [23:0] tbl_score [ENTRIES];
    logic [15:0] tbl_count [ENTRIES];
    logic [15:0] r_expiry, r_slimit, r_climit, r_bonus, r_dofs, r_dscale;

    verdict_t   verdicts_due[$];
    idle_mode_t idle_mode = IDLE_NONE;
    int         errors = 0;
    int         hold_off = 0;
    int         n_items = 0;
    int         n_blocked = 0;
    int         n_rejected = 0;
    int         n_released = 0;
    longint     cycles = 0;

    function automatic bit is_blocked(int k);
        return tbl_score[k] > {r_slimit, 8'd0} && tbl_count[k] > r_climit;
    endfunction

    function automatic void rel_bump(ref logic [9:0] r);
        if (r != REL_MAX) r++;
    endfunction

    function automatic verdict_t judge_attempt(logic [31:0] addr, logic [31:0] now);
        verdict_t    v;
        logic [9:0]  rel;
        logic [31:0] t;
        int          hk, victim;
        bit          was, found;
        longint unsigned den, q, best;
        rel = '0;
        hk = -1;
        for (int k = 0; k < ENTRIES; k++) begin
            t = tbl_time[k];
            if (t == 0) continue;
            if (now < t || (now - t) > r_expiry) begin
                if (is_blocked(k)) rel_bump(rel);
                tbl_time[k] = '0;
                continue;
            end
            if (tbl_addr[k] == addr) begin
                hk = k;
                break;
            end
        end
        v.releases = rel;
        if (hk >= 0) begin
            was = is_blocked(hk);
            if (!was) begin
                den = longint'(now - tbl_time[hk]) + r_dofs;
                if (den == 0) q = (tbl_score[hk] == 0) ? 0 : SCORE_MAX;
                else q = (longint'(tbl_score[hk]) * r_dscale) / den;
                q += longint'(r_bonus) << 8;
                if (q > SCORE_MAX) q = SCORE_MAX;
                tbl_score[hk] = q[23:0];
            end
            if (tbl_count[hk] != COUNT_MAX) tbl_count[hk]++;
            v.attempt_count = tbl_count[hk];
            if (is_blocked(hk)) begin
                v.accept = 1'b0;
                v.newly_blocked = !was;
            end else begin
                tbl_time[hk] = now;
                v.accept = 1'b1;
                v.newly_blocked = 1'b0;
            end
            return v;
        end
        found = 0;
        victim = 0;
        best = longint'(now) + 1;
        for (int k = 0; k < ENTRIES; k++)
            if (tbl_time[k] < best && !is_blocked(k)) begin
                best = tbl_time[k];
                victim = k;
                found = 1;
            end
        if (!found) begin
            best = longint'(now) + 1;
            for (int k = 0; k < ENTRIES; k++)
                if (tbl_time[k] < best) begin
                    best = tbl_time[k];
                    victim = k;
                end
        end
        if (is_blocked(victim)) rel_bump(rel);
        tbl_addr[victim]  = addr;
        tbl_time[victim]  = now;
        tbl_score[victim] = '0;
        tbl_count[victim] = 16'd1;
        v.accept = 1'b1;
        v.newly_blocked = 1'b0;
        v.releases = rel;
        v.attempt_count = 16'd1;
        return v;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // receiver: random stalls, long hold-off on request
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_tready = 1'b0;
            hold_off = hold_off - 1;
        end else if (idle_mode == IDLE_RECV)
            m_tready = ($urandom_range(99) >= 66);
        else if (idle_mode == IDLE_BOTH)
            m_tready = ($urandom_range(99) >= 15);
        else
            m_tready = 1'b1;
    end

    always @(posedge aclk) begin
        verdict_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[27:0];
            if (verdicts_due.size() == 0) begin
                report("unexpected item", m_tdata, 0);
            end else begin
                want = verdicts_due.pop_front();
                if (got.accept != want.accept)
                    report("accept", 32'(got.accept), 32'(want.accept));
                if (got.newly_blocked != want.newly_blocked)
                    report("newly_blocked", 32'(got.newly_blocked),
                           32'(want.newly_blocked));
                if (got.releases != want.releases)
                    report("releases", 32'(got.releases), 32'(want.releases));
                if (got.attempt_count != want.attempt_count)
                    report("attempt_count", 32'(got.attempt_count),
                           32'(want.attempt_count));
                if (m_tdata[31:28] != 0) report("pad bits", 32'(m_tdata[31:28]), 0);
            end
        end
    end

    task automatic send_attempt(logic [31:0] addr, logic [31:0] now);
        verdict_t v;
        int gap;
        gap = 0;
        if (idle_mode == IDLE_SEND && $urandom_range(99) < 66) gap = $urandom_range(1, 4);
        if (idle_mode == IDLE_BOTH && $urandom_range(99) < 15) gap = $urandom_range(1, 4);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {now, addr};
        do @(posedge aclk); while (!s_tready);
        v = judge_attempt(addr, now);
        verdicts_due.push_back(v);
        n_items++;
        if (v.newly_blocked) n_blocked++;
        if (!v.accept) n_rejected++;
        n_released += v.releases;
    endtask

    task automatic drain;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (verdicts_due.size() > 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_EXPIRY:      r_expiry = val;
            CFG_SCORE_LIMIT: r_slimit = val;
            CFG_COUNT_LIMIT: r_climit = val;
            CFG_SCORE_BONUS: r_bonus  = val;
            CFG_DECAY_OFS:   r_dofs   = val;
            CFG_DECAY_SCALE: r_dscale = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(logic [15:0] ex, logic [15:0] sl, logic [15:0] cl,
                             logic [15:0] bo, logic [15:0] dof, logic [15:0] dsc);
        write_reg(CFG_EXPIRY, ex);
        write_reg(CFG_SCORE_LIMIT, sl);
        write_reg(CFG_COUNT_LIMIT, cl);
        write_reg(CFG_SCORE_BONUS, bo);
        write_reg(CFG_DECAY_OFS, dof);
        write_reg(CFG_DECAY_SCALE, dsc);
    endtask

    task automatic test_reset_defaults;
        send_attempt(32'h0, 32'd1);
        send_attempt(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int i = 0; i < 18; i++) send_attempt(32'hC0A8_0101, 32'd1000);
        send_attempt(32'hC0A8_0101, 32'd999);   // time runs backwards: entry cleared
        send_attempt(32'hC0A8_0101, 32'd1700);  // past expiry
        drain();
    endtask

    task automatic test_register_extremes;
        write_all(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        write_reg(CFG_SPARE_A, 16'h1234);
        write_reg(CFG_SPARE_B, 16'hFFFF);
        send_attempt(32'h0A00_0001, 32'd60);
        send_attempt(32'h0A00_0001, 32'd60);    // zero divisor, zero score
        send_attempt(32'h0A00_0001, 32'd60);    // zero divisor, score saturates
        send_attempt(32'h0A00_0001, 32'd61);
        send_attempt(32'h0A00_0001, 32'd63);
        drain();
        write_all(16'hFFFF, 16'd0, 16'd0, 16'd30, 16'd1, 16'd1);
        send_attempt(32'h0A00_0002, 32'd70);
        send_attempt(32'h0A00_0002, 32'd70);    // blocked on second attempt
        send_attempt(32'h0A00_0002, 32'd71);
        drain();
    endtask

    task automatic test_random_traffic;
        logic [31:0] pool [8];
        logic [31:0] now, addr;
        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = idle_mode_t'(ph);
            if (ph == 0)
                write_all(RST_EXPIRY, RST_SCORE_LIMIT, RST_COUNT_LIMIT, RST_SCORE_BONUS,
                          RST_DECAY_OFS, RST_DECAY_SCALE);
            else
                write_all(16'($urandom_range(20, 1000)), 16'($urandom_range(0, 200)),
                          16'($urandom_range(0, 20)), 16'($urandom_range(0, 100)),
                          16'($urandom_range(1, 60)), 16'($urandom_range(1, 100)));
            foreach (pool[i]) pool[i] = $urandom();
            now = $urandom_range(1, 32'hFFFF_0000);
            for (int i = 0; i < 100; i++) begin
                addr = ($urandom_range(99) < 12) ? $urandom() : pool[$urandom_range(7)];
                case ($urandom_range(19))
                    0: now = now - $urandom_range(1, 50);
                    1: now = now + $urandom_range(500, 3000);
                    2: now = $urandom();
                    default: now = now + $urandom_range(0, 8);
                endcase
                if (now == 0) now = 1;
                send_attempt(addr, now);
            end
            drain();
        end
        idle_mode = IDLE_NONE;
    endtask

    task automatic test_output_backpressure;
        write_all(RST_EXPIRY, 16'd10, 16'd3, RST_SCORE_BONUS, RST_DECAY_OFS, RST_DECAY_SCALE);
        hold_off = 3000;
        for (int i = 0; i < 6; i++) send_attempt(32'h0B00_0007, 32'd5000 + i);
        drain();
    endtask

    task automatic test_blocked_expiry;
        write_all(16'd50, 16'd0, 16'd0, 16'd30, RST_DECAY_OFS, RST_DECAY_SCALE);
        for (int i = 0; i < 24; i++) begin
            send_attempt(32'h5000_0000 + i, 32'd100 + i);
            if (i % 3 == 0) send_attempt(32'h5000_0000 + i, 32'd100 + i);
        end
        for (int i = 0; i < 8; i++) send_attempt(32'h6000_0000 + i, 32'd140 + i);
        send_attempt(32'h6000_0000, 32'd200);   // blocked entries age out
        send_attempt(32'h5000_0000, 32'd201);
        drain();
    endtask

    initial begin
        foreach (tbl_time[k]) begin
            tbl_addr[k] = '0;
            tbl_time[k] = '0;
            tbl_score[k] = '0;
            tbl_count[k] = '0;
        end
        r_expiry = RST_EXPIRY;
        r_slimit = RST_SCORE_LIMIT;
        r_climit = RST_COUNT_LIMIT;
        r_bonus  = RST_SCORE_BONUS;
        r_dofs   = RST_DECAY_OFS;
        r_dscale = RST_DECAY_SCALE;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_blocked_expiry();

        repeat (ENTRIES + 60) @(posedge aclk);
        $display("covered %0d attempts: %0d newly blocked, %0d rejected, %0d releases",
                 n_items, n_blocked, n_rejected, n_released);
        $display("register extremes, stalls, long output hold-off and blocked entries ageing out were run");
        if (errors == 0 && verdicts_due.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

FILE: connection_flood_limiter.f
hw/rtl/cfl_pkg.sv
hw/rtl/cfl_ram.sv
hw/rtl/cfl_div.sv
hw/rtl/connection_flood_limiter.sv
tb/tb.sv
